// ----- design/prpt_pkg.sv -----
// shared types, constants and character codes for the position report parser table
package prpt_pkg;

    localparam int TABLE_ENTRIES = 32;
    localparam int ID_BYTES      = 16;

    localparam int ID_W     = ID_BYTES * 8;
    localparam int IDX_W    = $clog2(ID_BYTES);
    localparam int OFS_W    = 6;
    localparam int SLOT_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int LAT_W    = 21;
    localparam int LON_W    = 24;
    localparam int REFLAT_W = 21;
    localparam int REFLON_W = 22;
    localparam int DIFF_W   = 26;
    localparam int QPTR_W   = 1;
    localparam int QUEUE_DEPTH = 1 << QPTR_W;

    localparam int WINDOW   = 6000;
    localparam int SKIP_LEN = 7;
    localparam int POS_LEN  = 18;
    localparam int POS_MIN  = 17;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_W     = 8'h57;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;

    localparam logic [2:0] ST_NOPOS   = 3'd0;
    localparam logic [2:0] ST_OUTSIDE = 3'd1;
    localparam logic [2:0] ST_UPDATED = 3'd2;
    localparam logic [2:0] ST_ADDED   = 3'd3;
    localparam logic [2:0] ST_FULL    = 3'd4;

    localparam logic CFG_REF_LAT = 1'b0;
    localparam logic CFG_REF_LON = 1'b1;

    typedef struct packed {
        logic              have;
        logic [LAT_W-1:0]  lat;
        logic [LON_W-1:0]  lon;
        logic [ID_W-1:0]   id;
    } t_line_rec;

endpackage

// ----- design/position_report_parser_table_unit.sv -----
// top level of the position report parser with station table
//
//  channel   dir  handshake                  payload
//  rx        in   i_rx_valid / o_rx_ready    i_rx_byte
//  result    out  o_res_valid / i_res_ready  o_status o_slot o_lat o_lon
//  config    in   i_cfg_valid / o_cfg_ready  i_cfg_index i_cfg_data
//
// the parser takes one byte per cycle; a newline pushes a line record into a
// two deep queue and stalls rx only while that queue is full
// a line end with no position or outside the window is answered from the idle
// state, otherwise a table scan steps each entry through S_ADDR and S_CMP for the id ram read
// the result sits in an output register; the scan of the next line waits for it
// synchronous active low reset clears parser, queue, valid bits and references
module position_report_parser_table_unit import prpt_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_rx_valid,
    output logic                o_rx_ready,
    input  logic [7:0]          i_rx_byte,
    output logic                o_res_valid,
    input  logic                i_res_ready,
    output logic [2:0]          o_status,
    output logic [4:0]          o_slot,
    output logic signed [LAT_W-1:0] o_lat,
    output logic signed [LON_W-1:0] o_lon,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_index,
    input  logic [REFLON_W-1:0] i_cfg_data
);
    logic [REFLAT_W-1:0] r_ref_lat;
    logic [REFLON_W-1:0] r_ref_lon;

    t_line_rec front_rec, queue_rec;
    logic      push, pop, full, empty;
    logic [LAT_W-1:0] lat_bits;
    logic [LON_W-1:0] lon_bits;

    // config transactions are always taken
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_lat <= '0;
            r_ref_lon <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_REF_LAT: r_ref_lat <= i_cfg_data[REFLAT_W-1:0];
                CFG_REF_LON: r_ref_lon <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // front: byte parser
    prpt_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_rx_valid),
        .o_ready   (o_rx_ready),
        .i_rx_byte (i_rx_byte),
        .i_full    (full),
        .o_push    (push),
        .o_rec     (front_rec)
    );

    // queue of finished lines
    prpt_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (front_rec),
        .i_pop   (pop),
        .o_rec   (queue_rec),
        .o_full  (full),
        .o_empty (empty)
    );

    // back: station table
    prpt_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_empty   (empty),
        .i_rec     (queue_rec),
        .o_pop     (pop),
        .i_ref_lat (r_ref_lat),
        .i_ref_lon (r_ref_lon),
        .o_valid   (o_res_valid),
        .i_ready   (i_res_ready),
        .o_status  (o_status),
        .o_slot    (o_slot),
        .o_lat     (lat_bits),
        .o_lon     (lon_bits)
    );

    assign o_lat = $signed(lat_bits);
    assign o_lon = $signed(lon_bits);
endmodule

// ----- design/prpt_ram.sv -----
// generic single write port ram with registered read
module prpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- design/prpt_front.sv -----
// line parser: takes bytes, builds id and position, emits one record per line
module prpt_front import prpt_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_rx_byte,
    input  logic       i_full,
    output logic       o_push,
    output t_line_rec  o_rec
);
    typedef enum logic [2:0] {
        PH_ID, PH_ID_CLOSED, PH_TYPE, PH_SKIP, PH_POS, PH_DONE, PH_NOPOS
    } t_phase;

    t_phase           r_phase, n_phase;
    logic [OFS_W-1:0] r_ofs, n_ofs;
    logic [7:0]       r_pend, n_pend;
    logic [7:0]       r_id [ID_BYTES];
    logic [7:0]       n_id [ID_BYTES];
    logic [LAT_W-1:0] r_lat, n_lat;
    logic [LON_W-1:0] r_lon, n_lon;

    logic       acc, is_lf, take;
    logic [7:0] c;
    logic       dig, ok;
    logic [3:0] d;
    logic [LAT_W-1:0] d_lat;
    logic [LON_W-1:0] d_lon;

    assign o_ready = !i_full;
    assign acc     = i_valid && !i_full;
    assign is_lf   = (i_rx_byte == CH_LF);
    assign take    = acc && (i_rx_byte != CH_NUL) && !is_lf && (r_pend != CH_NUL);
    assign c       = r_pend;
    assign dig     = (c >= CH_0) && (c <= CH_9);
    assign d       = 4'(c - CH_0);
    assign d_lat   = LAT_W'(d);
    assign d_lon   = LON_W'(d);
    assign o_push  = acc && is_lf;

    always_comb begin
        o_rec.have = (r_phase == PH_DONE) ||
                     ((r_phase == PH_POS) && (r_ofs >= OFS_W'(POS_MIN)));
        o_rec.lat  = r_lat;
        o_rec.lon  = r_lon;
        for (int k = 0; k < ID_BYTES; k++) begin
            o_rec.id[k*8 +: 8] = r_id[k];
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_ofs   = r_ofs;
        n_pend  = r_pend;
        n_id    = r_id;
        n_lat   = r_lat;
        n_lon   = r_lon;
        ok      = 1'b1;
        if (take) begin
            case (r_phase)
                PH_ID: begin
                    if (c == CH_COLON) begin
                        n_phase = PH_TYPE;
                        n_ofs   = '0;
                    end else if (c == CH_COMMA) begin
                        n_phase = PH_ID_CLOSED;
                    end else if (r_ofs < OFS_W'(ID_BYTES)) begin
                        n_id[r_ofs[IDX_W-1:0]] = c;
                        n_ofs = r_ofs + 1'b1;
                    end
                end
                PH_ID_CLOSED: begin
                    if (c == CH_COLON) begin
                        n_phase = PH_TYPE;
                        n_ofs   = '0;
                    end
                end
                PH_TYPE: begin
                    n_ofs = '0;
                    if (c == CH_BANG || c == CH_EQ) n_phase = PH_POS;
                    else if (c == CH_SLASH || c == CH_AT) n_phase = PH_SKIP;
                    else n_phase = PH_NOPOS;
                end
                PH_SKIP: begin
                    n_ofs = r_ofs + 1'b1;
                    if (n_ofs >= OFS_W'(SKIP_LEN)) begin
                        n_phase = PH_POS;
                        n_ofs   = '0;
                    end
                end
                PH_POS: begin
                    case (r_ofs)
                        6'd0, 6'd1: begin
                            ok = dig;
                            n_lat = LAT_W'(r_lat * LAT_W'(10) + d_lat);
                        end
                        6'd2: begin
                            ok = dig;
                            n_lat = LAT_W'(r_lat * LAT_W'(6000) + d_lat * LAT_W'(1000));
                        end
                        6'd3: begin ok = dig; n_lat = LAT_W'(r_lat + d_lat * LAT_W'(100)); end
                        6'd4: ok = (c == CH_DOT);
                        6'd5: begin ok = dig; n_lat = LAT_W'(r_lat + d_lat * LAT_W'(10)); end
                        6'd6: begin ok = dig; n_lat = LAT_W'(r_lat + d_lat); end
                        6'd7: if (c == CH_S) n_lat = LAT_W'(0) - r_lat;
                        6'd9, 6'd10, 6'd11: begin
                            ok = dig;
                            n_lon = LON_W'(r_lon * LON_W'(10) + d_lon);
                        end
                        6'd12: begin
                            ok = dig;
                            n_lon = LON_W'(r_lon * LON_W'(6000) + d_lon * LON_W'(1000));
                        end
                        6'd13: begin ok = dig; n_lon = LON_W'(r_lon + d_lon * LON_W'(100)); end
                        6'd14: ok = (c == CH_DOT);
                        6'd15: begin ok = dig; n_lon = LON_W'(r_lon + d_lon * LON_W'(10)); end
                        6'd16: begin ok = dig; n_lon = LON_W'(r_lon + d_lon); end
                        6'd17: if (c == CH_W) n_lon = LON_W'(0) - r_lon;
                        default: ok = 1'b1;
                    endcase
                    if (!ok) begin
                        n_phase = PH_NOPOS;
                        n_lat   = r_lat;
                        n_lon   = r_lon;
                    end else begin
                        n_ofs = r_ofs + 1'b1;
                        if (n_ofs >= OFS_W'(POS_LEN)) n_phase = PH_DONE;
                    end
                end
                default: ;
            endcase
        end
        if (acc && (i_rx_byte != CH_NUL) && !is_lf) begin
            n_pend = i_rx_byte;
        end
        // newline: record goes to the queue, line state starts over
        if (o_push) begin
            n_phase = PH_ID;
            n_ofs   = '0;
            n_pend  = CH_NUL;
            n_lat   = '0;
            n_lon   = '0;
            for (int k = 0; k < ID_BYTES; k++) n_id[k] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_ID;
            r_ofs   <= '0;
            r_pend  <= CH_NUL;
            r_lat   <= '0;
            r_lon   <= '0;
            for (int k = 0; k < ID_BYTES; k++) r_id[k] <= '0;
        end else begin
            r_phase <= n_phase;
            r_ofs   <= n_ofs;
            r_pend  <= n_pend;
            r_lat   <= n_lat;
            r_lon   <= n_lon;
            r_id    <= n_id;
        end
    end
endmodule

// ----- design/prpt_fifo.sv -----
// short queue of finished line records between parser and table unit
module prpt_fifo import prpt_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_line_rec i_rec,
    input  logic      i_pop,
    output t_line_rec o_rec,
    output logic      o_full,
    output logic      o_empty
);
    t_line_rec         r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp, r_rp;
    logic [QPTR_W:0]   r_cnt;

    assign o_full  = (r_cnt == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_rec   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_rec;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            if (i_push && !i_pop) r_cnt <= r_cnt + 1'b1;
            else if (!i_push && i_pop) r_cnt <= r_cnt - 1'b1;
        end
    end
endmodule

// ----- design/prpt_back.sv -----
// table unit: window check, station scan, update or insert, result register
module prpt_back import prpt_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_empty,
    input  t_line_rec           i_rec,
    output logic                o_pop,
    input  logic [REFLAT_W-1:0] i_ref_lat,
    input  logic [REFLON_W-1:0] i_ref_lon,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [2:0]          o_status,
    output logic [4:0]          o_slot,
    output logic [LAT_W-1:0]    o_lat,
    output logic [LON_W-1:0]    o_lon
);
    typedef enum logic [1:0] {S_IDLE, S_ADDR, S_CMP} t_state;

    t_state              r_state;
    logic [SLOT_W-1:0]   r_n;
    logic [ID_W-1:0]     r_id;
    logic [TABLE_ENTRIES-1:0] r_valid;
    logic                r_free_hit;
    logic [SLOT_W-1:0]   r_free_slot;
    logic [SLOT_W-1:0]   r_slot;

    logic              out_free, start, posok, outside, last, match, cur_free;
    logic              we;
    logic [SLOT_W-1:0] free_slot;
    logic [ID_W-1:0]   rdata;
    logic signed [DIFF_W-1:0] dla, dlo;

    assign out_free = !o_valid || i_ready;
    assign start    = (r_state == S_IDLE) && !i_empty && out_free;
    assign o_pop    = start;
    assign posok    = i_rec.have && (i_rec.lat != '0) && (i_rec.lon != '0);
    assign dla = $signed(DIFF_W'($signed(i_rec.lat))) - $signed(DIFF_W'($signed(i_ref_lat)));
    assign dlo = $signed(DIFF_W'($signed(i_rec.lon))) - $signed(DIFF_W'($signed(i_ref_lon)));
    assign outside = (dla >= DIFF_W'(WINDOW)) || (dla <= -DIFF_W'(WINDOW)) ||
                     (dlo >= DIFF_W'(WINDOW)) || (dlo <= -DIFF_W'(WINDOW));
    assign last      = (r_n == SLOT_W'(TABLE_ENTRIES - 1));
    assign match     = r_valid[r_n] && (rdata == r_id);
    assign cur_free  = !r_valid[r_n];
    assign free_slot = r_free_hit ? r_free_slot : r_n;
    assign we        = (r_state == S_CMP) && last && !match && (r_free_hit || cur_free);
    assign o_slot    = 5'(r_slot);

    prpt_ram #(.WIDTH(ID_W), .DEPTH(TABLE_ENTRIES)) u_id_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (free_slot),
        .i_wdata (r_id),
        .i_raddr (r_n),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_valid    <= '0;
            o_valid    <= 1'b0;
            r_n        <= '0;
            r_free_hit <= 1'b0;
        end else begin
            if (o_valid && i_ready) o_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        o_lat <= i_rec.lat;
                        o_lon <= i_rec.lon;
                        r_id  <= i_rec.id;
                        r_slot <= '0;
                        if (!posok) begin
                            o_valid  <= 1'b1;
                            o_status <= ST_NOPOS;
                            o_lat    <= '0;
                            o_lon    <= '0;
                        end else if (outside) begin
                            o_valid  <= 1'b1;
                            o_status <= ST_OUTSIDE;
                        end else begin
                            r_n        <= '0;
                            r_free_hit <= 1'b0;
                            r_state    <= S_ADDR;
                        end
                    end
                end
                S_ADDR: r_state <= S_CMP;
                S_CMP: begin
                    if (match) begin
                        o_valid  <= 1'b1;
                        o_status <= ST_UPDATED;
                        r_slot   <= r_n;
                        r_state  <= S_IDLE;
                    end else if (last) begin
                        o_valid <= 1'b1;
                        r_state <= S_IDLE;
                        if (we) begin
                            o_status <= ST_ADDED;
                            r_slot   <= free_slot;
                            r_valid[free_slot] <= 1'b1;
                        end else begin
                            o_status <= ST_FULL;
                        end
                    end else begin
                        if (cur_free && !r_free_hit) begin
                            r_free_hit  <= 1'b1;
                            r_free_slot <= r_n;
                        end
                        r_n     <= r_n + 1'b1;
                        r_state <= S_ADDR;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ----- tb/sv/testbench.sv -----
// self-checking testbench for the position report parser with station table
module testbench;
    import prpt_pkg::*;

    typedef struct {
        logic [2:0]        status;
        logic [4:0]        slot;
        logic [LAT_W-1:0]  lat;
        logic [LON_W-1:0]  lon;
    } t_report;

    typedef enum int {
        LN_ID, LN_ID_CLOSED, LN_TYPE, LN_SKIP, LN_POS, LN_DONE, LN_NOPOS
    } t_line_phase;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_rx_valid;
    logic                o_rx_ready;
    logic [7:0]          i_rx_byte;
    logic                o_res_valid;
    logic                i_res_ready;
    logic [2:0]          o_status;
    logic [4:0]          o_slot;
    logic signed [LAT_W-1:0] o_lat;
    logic signed [LON_W-1:0] o_lon;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic                i_cfg_index;
    logic [REFLON_W-1:0] i_cfg_data;

    position_report_parser_table_unit dut (.*);

    // stimulus and scoreboard storage
    logic [7:0] tx_bytes[$];
    t_report    expected_reports[$];
    int         error_count = 0;
    int         cycle_count = 0;

    // predictor state, mirrors the block
    int          ref_lat_q, ref_lon_q;
    t_line_phase phase_q;
    int          offset_q;
    logic [7:0]  held_char;
    logic [ID_W-1:0] id_acc;
    int          lat_acc, lon_acc;
    logic        stn_valid[TABLE_ENTRIES];
    logic [ID_W-1:0] stn_id[TABLE_ENTRIES];

    initial begin
        i_clk = 1'b0;
    end
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor

    function automatic void clear_line_state();
        phase_q   = LN_ID;
        offset_q  = 0;
        held_char = CH_NUL;
        id_acc    = '0;
        lat_acc   = 0;
        lon_acc   = 0;
    endfunction

    // one character of the fixed position layout, 0 on a bad character
    function automatic bit take_pos_char(int idx, logic [7:0] c);
        bit dig;
        int d;
        dig = (c >= CH_0 && c <= CH_9);
        d = dig ? int'(c - CH_0) : 0;
        case (idx)
            0, 1: begin
                if (!dig) return 0;
                lat_acc = lat_acc * 10 + d;
            end
            2: begin
                if (!dig) return 0;
                lat_acc = lat_acc * 6000 + d * 1000;
            end
            3: begin if (!dig) return 0; lat_acc += d * 100; end
            4: return c == CH_DOT;
            5: begin if (!dig) return 0; lat_acc += d * 10; end
            6: begin if (!dig) return 0; lat_acc += d; end
            7: if (c == CH_S) lat_acc = -lat_acc;
            9, 10, 11: begin
                if (!dig) return 0;
                lon_acc = lon_acc * 10 + d;
            end
            12: begin
                if (!dig) return 0;
                lon_acc = lon_acc * 6000 + d * 1000;
            end
            13: begin if (!dig) return 0; lon_acc += d * 100; end
            14: return c == CH_DOT;
            15: begin if (!dig) return 0; lon_acc += d * 10; end
            16: begin if (!dig) return 0; lon_acc += d; end
            17: if (c == CH_W) lon_acc = -lon_acc;
            default: ;
        endcase
        return 1;
    endfunction

    function automatic void advance_parser(logic [7:0] c);
        case (phase_q)
            LN_ID: begin
                if (c == CH_COLON) begin
                    phase_q = LN_TYPE;
                    offset_q = 0;
                end else if (c == CH_COMMA) begin
                    phase_q = LN_ID_CLOSED;
                end else if (offset_q < ID_BYTES) begin
                    id_acc[offset_q*8 +: 8] = c;
                    offset_q++;
                end
            end
            LN_ID_CLOSED: begin
                if (c == CH_COLON) begin
                    phase_q = LN_TYPE;
                    offset_q = 0;
                end
            end
            LN_TYPE: begin
                offset_q = 0;
                if (c == CH_BANG || c == CH_EQ) phase_q = LN_POS;
                else if (c == CH_SLASH || c == CH_AT) phase_q = LN_SKIP;
                else phase_q = LN_NOPOS;
            end
            LN_SKIP: begin
                offset_q++;
                if (offset_q >= SKIP_LEN) begin
                    phase_q = LN_POS;
                    offset_q = 0;
                end
            end
            LN_POS: begin
                if (!take_pos_char(offset_q, c)) begin
                    phase_q = LN_NOPOS;
                end else begin
                    offset_q++;
                    if (offset_q >= POS_LEN) phase_q = LN_DONE;
                end
            end
            default: ;
        endcase
    endfunction

    // line end: window test, then table update or insert
    function automatic t_report close_line();
        t_report r;
        bit have;
        int dla, dlo;
        r.status = ST_NOPOS;
        r.slot = '0;
        r.lat = '0;
        r.lon = '0;
        have = (phase_q == LN_DONE) || (phase_q == LN_POS && offset_q >= POS_MIN);
        if (have && lat_acc != 0 && lon_acc != 0) begin
            dla = lat_acc - ref_lat_q;
            dlo = lon_acc - ref_lon_q;
            r.lat = lat_acc[LAT_W-1:0];
            r.lon = lon_acc[LON_W-1:0];
            if (dla >= WINDOW || dla <= -WINDOW || dlo >= WINDOW || dlo <= -WINDOW) begin
                r.status = ST_OUTSIDE;
            end else begin
                r.status = ST_FULL;
                for (int n = 0; n < TABLE_ENTRIES; n++) begin
                    if (stn_valid[n] && stn_id[n] == id_acc) begin
                        r.status = ST_UPDATED;
                        r.slot = n[4:0];
                        break;
                    end
                end
                if (r.status == ST_FULL) begin
                    for (int n = 0; n < TABLE_ENTRIES; n++) begin
                        if (!stn_valid[n]) begin
                            stn_valid[n] = 1'b1;
                            stn_id[n] = id_acc;
                            r.status = ST_ADDED;
                            r.slot = n[4:0];
                            break;
                        end
                    end
                end
            end
        end
        return r;
    endfunction

    function automatic void predict_byte(logic [7:0] b);
        if (b == CH_NUL) return;
        if (b == CH_LF) begin
            expected_reports.push_back(close_line());
            clear_line_state();
            return;
        end
        // the byte before the newline never reaches the parser
        if (held_char != CH_NUL) advance_parser(held_char);
        held_char = b;
    endfunction

    // ---------------------------------------------------------------- stimulus

    function automatic void push_text(string s);
        for (int i = 0; i < s.len(); i++) tx_bytes.push_back(s[i]);
    endfunction

    function automatic string coord_text(int v, int deg_digits, string pos_h,
                                         string neg_h);
        int mag;
        mag = (v < 0) ? -v : v;
        if (deg_digits == 2)
            return $sformatf("%02d%02d.%02d%s", mag / 6000, (mag % 6000) / 100,
                             mag % 100, (v < 0) ? neg_h : pos_h);
        return $sformatf("%03d%02d.%02d%s", mag / 6000, (mag % 6000) / 100,
                         mag % 100, (v < 0) ? neg_h : pos_h);
    endfunction

    function automatic string digit_run(int n);
        string s = "";
        for (int i = 0; i < n; i++) s = {s, $sformatf("%0d", $urandom_range(0, 9))};
        return s;
    endfunction

    function automatic int clamp(int v, int lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    // one random line: mostly well-formed reports, some damaged, some noise
    function automatic void gen_line();
        string s, p, tail;
        int kind, lat, lon, k;
        kind = $urandom_range(0, 99);
        if (kind < 78) begin
            s = $sformatf("K%0d", $urandom_range(0, 47));
            if ($urandom_range(0, 3) == 0) s = {s, ",WIDE1-1,qAR"};
            case ($urandom_range(0, 3))
                0: s = {s, ":!"};
                1: s = {s, ":="};
                2: s = {s, ":/", digit_run(6), "z"};
                default: s = {s, ":@", digit_run(6), "h"};
            endcase
            if ($urandom_range(0, 4) == 0) begin
                // raw digits cover the full field range
                p = {digit_run(4), ".", digit_run(2), ($urandom_range(0, 1) ? "S" : "N"),
                     "/", digit_run(5), ".", digit_run(2),
                     ($urandom_range(0, 1) ? "W" : "E")};
            end else begin
                lat = clamp(ref_lat_q + $urandom_range(0, 13000) - 6500, 599999);
                lon = clamp(ref_lon_q + $urandom_range(0, 13000) - 6500, 5999999);
                p = {coord_text(lat, 2, "N", "S"), ">", coord_text(lon, 3, "E", "W")};
            end
            k = $urandom_range(0, 19);
            if (k == 0) p[$urandom_range(0, 17)] = 8'($urandom_range(58, 126));
            else if (k == 1) p = p.substr(0, $urandom_range(0, 17));
            s = {s, p};
            if ($urandom_range(0, 2) == 0) s = {s, "comment text"};
            tail = ($urandom_range(0, 4) != 0) ? "\r" : "";
            push_text({s, tail});
            if ($urandom_range(0, 9) == 0) tx_bytes.push_back(CH_NUL);
        end else begin
            k = $urandom_range(1, 24);
            for (int i = 0; i < k; i++) begin
                logic [7:0] b;
                b = 8'($urandom_range(0, 255));
                if (b == CH_LF) b = 8'hFF;
                tx_bytes.push_back(b);
            end
        end
        tx_bytes.push_back(CH_LF);
    endfunction

    // ---------------------------------------------------------------- driver

    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_rx_valid <= 1'b0;
            i_rx_byte  <= '0;
        end else if (!i_rx_valid || o_rx_ready) begin
            if (gap_left > 0) begin
                i_rx_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (tx_bytes.size() > 0) begin
                i_rx_valid <= 1'b1;
                i_rx_byte  <= tx_bytes.pop_front();
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_rx_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- receiver

    int hold_left  = 0;
    int mode_left  = 0;
    bit mode_stall = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_res_ready <= 1'b0;
        end else begin
            if (cycle_count == 200) begin
                // long hold-off so the line queue fills and rx stalls
                hold_left <= 900;
                i_res_ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                i_res_ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode_left  <= $urandom_range(20, 200);
                    mode_stall <= $urandom_range(0, 1);
                end else begin
                    mode_left <= mode_left - 1;
                end
                i_res_ready <= mode_stall ? ($urandom_range(0, 3) == 0) : 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------- monitor

    always @(posedge i_clk) begin
        t_report e;
        if (i_rst_n) begin
            if (i_rx_valid && o_rx_ready) predict_byte(i_rx_byte);
            if (o_res_valid && i_res_ready) begin
                if (expected_reports.size() == 0) begin
                    $error("unexpected result transaction status=%0d", o_status);
                    error_count++;
                end else begin
                    e = expected_reports.pop_front();
                    if (o_status !== e.status) begin
                        $error("status expected %0d actual %0d", e.status, o_status);
                        error_count++;
                    end
                    if (o_slot !== e.slot) begin
                        $error("slot expected %0d actual %0d", e.slot, o_slot);
                        error_count++;
                    end
                    if (o_lat !== e.lat) begin
                        $error("lat expected %0d actual %0d", $signed(e.lat), o_lat);
                        error_count++;
                    end
                    if (o_lon !== e.lon) begin
                        $error("lon expected %0d actual %0d", $signed(e.lon), o_lon);
                        error_count++;
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------- watchdog

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 1500000) begin
            $display("FAIL position_report_parser_table_unit");
            $finish;
        end
    end

    // ---------------------------------------------------------------- sequence

    task automatic write_ref(logic idx, int value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value[REFLON_W-1:0];
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready) break;
        end
        i_cfg_valid <= 1'b0;
        if (idx == CFG_REF_LAT) ref_lat_q = $signed(value[REFLAT_W-1:0]);
        else ref_lon_q = $signed(value[REFLON_W-1:0]);
    endtask

    task automatic drain();
        while (tx_bytes.size() > 0 || expected_reports.size() > 0 || i_rx_valid)
            @(posedge i_clk);
        // a table scan can still be running
        repeat (150) @(posedge i_clk);
    endtask

    initial begin
        int ref_lats[4];
        int ref_lons[4];
        i_rst_n     = 1'b0;
        i_rx_valid  = 1'b0;
        i_rx_byte   = '0;
        i_res_ready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_REF_LAT;
        i_cfg_data  = '0;
        ref_lat_q = 0;
        ref_lon_q = 0;
        clear_line_state();
        for (int n = 0; n < TABLE_ENTRIES; n++) begin
            stn_valid[n] = 1'b0;
            stn_id[n] = '0;
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        ref_lats = '{0, -540000, 540000, 0};
        ref_lons = '{0, 1080000, -1080000, 0};
        ref_lats[3] = $urandom_range(0, 1080000) - 540000;
        ref_lons[3] = $urandom_range(0, 2160000) - 1080000;

        // directed lines at the reset reference
        push_text("A:!0030.00N/00030.00E\r\n");          // added
        push_text("A,RELAY:=0031.00S/00031.00W\r\n");    // updated, south and west
        push_text(":!0010.00N/00010.00E\r\n");           // empty id
        push_text("ABCDEFGHIJKLMNOPQRST:/123456z0012.00N/00012.00E\r\n"); // long id
        push_text("B:@123456h9999.99S/99999.99W\r\n");    // outside, largest digits
        push_text("C:!0000.00N/00012.00E\r\n");          // zero latitude
        push_text("D:!00x0.00N/00012.00E\r\n");          // bad digit
        push_text("E:!0010,00N/00012.00E\r\n");          // missing dot
        push_text("F:>0010.00N/00012.00E\r\n");          // other type byte
        push_text("G no colon\r\n");
        push_text("H:!0001.00N/00001.00\n");             // line ends before hemisphere
        tx_bytes.push_back(8'hFF);
        tx_bytes.push_back(CH_NUL);
        push_text("\n");

        for (int ph = 0; ph < 4; ph++) begin
            if (ph > 0) begin
                write_ref(CFG_REF_LAT, ref_lats[ph]);
                write_ref(CFG_REF_LON, ref_lons[ph]);
            end
            for (int i = 0; i < 6; i++) gen_line();
            drain();
        end

        if (error_count == 0) begin
            $display("PASS position_report_parser_table_unit");
        end else begin
            $display("FAIL position_report_parser_table_unit");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
design/prpt_pkg.sv
design/prpt_ram.sv
design/prpt_front.sv
design/prpt_fifo.sv
design/prpt_back.sv
design/position_report_parser_table_unit.sv
tb/sv/testbench.sv
